FILE: hdl/qvr_pkg.sv
// Shared constants for the quaternion vector rotation pipeline.
// No dependencies; imported by the matrix, multiply-accumulate and rounding stages.
package qvr_pkg;

  // Quaternion components are Q2.n: two integer bits, the rest fraction.
  localparam int unsigned QUAT_INT_BITS = 2;

  // Rows and columns of the rotation matrix.
  localparam int unsigned NUM_AXES = 3;

endpackage

FILE: hdl/qvr_matrix.sv
// Stages 1 and 2: quaternion component products, then rotation matrix entries.
// Depends on qvr_pkg.
module qvr_matrix import qvr_pkg::*; #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 24,
  localparam int PW = 2 * QUAT_WIDTH,
  localparam int MW = 2 * QUAT_WIDTH + 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_stall,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [VEC_WIDTH-1:0]  vec [NUM_AXES],
  output logic                        dn_valid,
  input  logic                        dn_stall,
  output logic signed [MW-1:0]        mat [NUM_AXES][NUM_AXES],
  output logic signed [VEC_WIDTH-1:0]  dn_vec [NUM_AXES]
);

  localparam int FRAC = QUAT_WIDTH - QUAT_INT_BITS;
  localparam logic signed [MW-1:0] UNIT = {{(MW-1){1'b0}}, 1'b1} << (2 * FRAC);

  logic v1_r, v2_r;
  logic adv1, adv2;

  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [VEC_WIDTH-1:0] vec1_r [NUM_AXES];
  logic signed [VEC_WIDTH-1:0] vec2_r [NUM_AXES];

  logic signed [MW-1:0] exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [MW-1:0] mat_nxt [NUM_AXES][NUM_AXES];
  logic signed [MW-1:0] mat_r   [NUM_AXES][NUM_AXES];

  // A stage moves when it is empty or the stage after it moves.
  assign adv2     = !v2_r || !dn_stall;
  assign adv1     = !v1_r || adv2;
  assign up_stall = !adv1;
  assign dn_valid = v2_r;
  assign mat      = mat_r;
  assign dn_vec   = vec2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= up_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && up_valid) begin
      xx_r   <= PW'(quat_x) * PW'(quat_x);
      yy_r   <= PW'(quat_y) * PW'(quat_y);
      zz_r   <= PW'(quat_z) * PW'(quat_z);
      xy_r   <= PW'(quat_x) * PW'(quat_y);
      xz_r   <= PW'(quat_x) * PW'(quat_z);
      yz_r   <= PW'(quat_y) * PW'(quat_z);
      wx_r   <= PW'(quat_w) * PW'(quat_x);
      wy_r   <= PW'(quat_w) * PW'(quat_y);
      wz_r   <= PW'(quat_w) * PW'(quat_z);
      vec1_r <= vec;
    end
  end

  assign exx = MW'(xx_r);
  assign eyy = MW'(yy_r);
  assign ezz = MW'(zz_r);
  assign exy = MW'(xy_r);
  assign exz = MW'(xz_r);
  assign eyz = MW'(yz_r);
  assign ewx = MW'(wx_r);
  assign ewy = MW'(wy_r);
  assign ewz = MW'(wz_r);

  // Entries carry 2*FRAC fractional bits, so one is UNIT.
  always_comb begin
    mat_nxt[0][0] = UNIT - ((eyy + ezz) <<< 1);
    mat_nxt[0][1] = (exy - ewz) <<< 1;
    mat_nxt[0][2] = (exz + ewy) <<< 1;
    mat_nxt[1][0] = (exy + ewz) <<< 1;
    mat_nxt[1][1] = UNIT - ((exx + ezz) <<< 1);
    mat_nxt[1][2] = (eyz - ewx) <<< 1;
    mat_nxt[2][0] = (exz - ewy) <<< 1;
    mat_nxt[2][1] = (eyz + ewx) <<< 1;
    mat_nxt[2][2] = UNIT - ((exx + eyy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      mat_r  <= mat_nxt;
      vec2_r <= vec1_r;
    end
  end

  a_matrix_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && dn_stall |=> v2_r && $stable(mat_r[0][0]) && $stable(mat_r[2][1]))
    else $error("matrix stage changed while stalled");

endmodule

FILE: hdl/qvr_mac.sv
// Stages 3 and 4: matrix-by-vector products, then row sums with the rounding offset.
// Depends on qvr_pkg.
module qvr_mac import qvr_pkg::*; #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 24,
  localparam int MW  = 2 * QUAT_WIDTH + 3,
  localparam int PRW = MW + VEC_WIDTH,
  localparam int SW  = PRW + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic signed [MW-1:0]       mat [NUM_AXES][NUM_AXES],
  input  logic signed [VEC_WIDTH-1:0] vec [NUM_AXES],
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic signed [SW-1:0]       acc [NUM_AXES]
);

  localparam int FRAC = QUAT_WIDTH - QUAT_INT_BITS;
  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (2 * FRAC - 1);

  logic v3_r, v4_r;
  logic adv3, adv4;

  logic signed [PRW-1:0] prod_r [NUM_AXES][NUM_AXES];
  logic signed [SW-1:0]  acc_r  [NUM_AXES];

  assign adv4     = !v4_r || !dn_stall;
  assign adv3     = !v3_r || adv4;
  assign up_stall = !adv3;
  assign dn_valid = v4_r;
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv3) begin
        v3_r <= up_valid;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && up_valid) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          prod_r[r][c] <= PRW'(mat[r][c]) * PRW'(vec[c]);
        end
      end
    end
  end

  // Exact row sums; adding one half here makes the later floor round to nearest.
  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        acc_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2]) + HALF;
      end
    end
  end

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && dn_stall |=> v4_r && $stable(acc_r[1]))
    else $error("sum stage changed while stalled");

endmodule

FILE: hdl/qvr_round.sv
// Stage 5: rescale, saturate and flag clamping into the output register.
// Depends on qvr_pkg.
module qvr_round import qvr_pkg::*; #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 24,
  localparam int SW = 2 * QUAT_WIDTH + 3 + VEC_WIDTH + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic signed [SW-1:0]       acc [NUM_AXES],
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic signed [VEC_WIDTH-1:0] rot [NUM_AXES],
  output logic                       clamped
);

  localparam int FRAC = QUAT_WIDTH - QUAT_INT_BITS;
  localparam int SHW  = SW - 2 * FRAC;
  localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  logic adv5;
  logic vld_r;
  logic clamped_r;
  logic signed [VEC_WIDTH-1:0] rot_r [NUM_AXES];

  logic signed [SHW-1:0]       scaled  [NUM_AXES];
  logic signed [VEC_WIDTH-1:0] rot_nxt [NUM_AXES];
  logic [NUM_AXES-1:0]         ovf;

  assign adv5     = !vld_r || !dn_stall;
  assign up_stall = !adv5;
  assign dn_valid = vld_r;
  assign rot      = rot_r;
  assign clamped  = clamped_r;

  // The value fits when all bits above the result's sign bit match it.
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      scaled[r] = SHW'(acc[r] >>> (2 * FRAC));
      ovf[r]    = !((&scaled[r][SHW-1:VEC_WIDTH-1]) || !(|scaled[r][SHW-1:VEC_WIDTH-1]));
      if (ovf[r]) begin
        rot_nxt[r] = scaled[r][SHW-1] ? VMIN : VMAX;
      end else begin
        rot_nxt[r] = scaled[r][VEC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv5) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5 && up_valid) begin
      rot_r     <= rot_nxt;
      clamped_r <= |ovf;
    end
  end

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && clamped_r |->
      (rot_r[0] == VMAX || rot_r[0] == VMIN || rot_r[1] == VMAX ||
       rot_r[1] == VMIN || rot_r[2] == VMAX || rot_r[2] == VMIN))
    else $error("clamp flag set with no component at a limit");

endmodule

FILE: hdl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation pipeline.
// Instantiates qvr_matrix, qvr_mac and qvr_round; constants come from qvr_pkg.
//
//   Channel  Ports                                   Handshake
//   input    in_quat_w/x/y/z, in_vec_x/y/z           in_valid, in_stall
//   output   out_rot_x/y/z, out_clamped              out_valid, out_stall
//
// Five register stages: component products, matrix entries, entry-by-vector
// products, row sums, round and saturate. One beat is taken every cycle
// while in_stall is low. Reset clears only the stage valid bits. Each stage
// moves when it is empty or its successor moves, so bubbles are squeezed out
// and in_stall rises only when all five stages hold beats and out_stall is high.
module quaternion_vector_rotate import qvr_pkg::*; #(
  parameter int VEC_WIDTH  = 24,
  parameter int QUAT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_w,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_x,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_y,
  input  logic signed [QUAT_WIDTH-1:0] in_quat_z,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]  in_vec_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VEC_WIDTH-1:0]  out_rot_x,
  output logic signed [VEC_WIDTH-1:0]  out_rot_y,
  output logic signed [VEC_WIDTH-1:0]  out_rot_z,
  output logic                        out_clamped
);

  localparam int MW  = 2 * QUAT_WIDTH + 3;
  localparam int SW  = MW + VEC_WIDTH + 2;

  logic signed [VEC_WIDTH-1:0] vec_in  [NUM_AXES];
  logic signed [VEC_WIDTH-1:0] vec_mat [NUM_AXES];
  logic signed [MW-1:0]        mat     [NUM_AXES][NUM_AXES];
  logic signed [SW-1:0]        acc     [NUM_AXES];
  logic signed [VEC_WIDTH-1:0] rot     [NUM_AXES];

  logic mat_valid, mat_stall;
  logic acc_valid, acc_stall;

  assign vec_in[0] = in_vec_x;
  assign vec_in[1] = in_vec_y;
  assign vec_in[2] = in_vec_z;

  qvr_matrix #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
  ) u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .quat_w   (in_quat_w),
    .quat_x   (in_quat_x),
    .quat_y   (in_quat_y),
    .quat_z   (in_quat_z),
    .vec      (vec_in),
    .dn_valid (mat_valid),
    .dn_stall (mat_stall),
    .mat      (mat),
    .dn_vec   (vec_mat)
  );

  qvr_mac #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mat_valid),
    .up_stall (mat_stall),
    .mat      (mat),
    .vec      (vec_mat),
    .dn_valid (acc_valid),
    .dn_stall (acc_stall),
    .acc      (acc)
  );

  qvr_round #(
    .QUAT_WIDTH (QUAT_WIDTH),
    .VEC_WIDTH  (VEC_WIDTH)
  ) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (acc_valid),
    .up_stall (acc_stall),
    .acc      (acc),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .rot      (rot),
    .clamped  (out_clamped)
  );

  assign out_rot_x = rot[0];
  assign out_rot_y = rot[1];
  assign out_rot_z = rot[2];

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid && acc_valid && mat_valid)
    else $error("input stalled while the pipeline could still move");

endmodule
